// ===== rtl/tqg_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-qubit gate state vector package
// Shared types, request codes and the gate matrix builder.
// ----------------------------------------------------------------------------
package tqg_pkg;

  localparam int AmpBits  = 18;
  localparam int ReqBits  = 2;
  localparam int FlagBits = 5;
  localparam int DirShift = 10;
  localparam int DirBits  = 2;
  localparam int SumBits  = AmpBits + 2;

  localparam logic [ReqBits-1:0] ReqWrite     = 2'd0;
  localparam logic [ReqBits-1:0] ReqTransform = 2'd1;
  localparam logic [ReqBits-1:0] ReqRead      = 2'd2;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StReadOut,
    StGrpRead,
    StGrpWrite
  } state_e;

  typedef logic signed [AmpBits-1:0] amp_t;
  typedef logic signed [1:0] coef_t;
  typedef coef_t mat_t [4][4];

  // Hadamard, right turn, left turn, reverse, swap.
  localparam int GateTab [5][4][4] = '{
    '{'{1, 1, 1, 1}, '{1, -1, 1, -1}, '{1, 1, -1, -1}, '{1, -1, -1, 1}},
    '{'{0, 0, 1, 0}, '{1, 0, 0, 0}, '{0, 0, 0, 1}, '{0, 1, 0, 0}},
    '{'{0, 1, 0, 0}, '{0, 0, 0, 1}, '{1, 0, 0, 0}, '{0, 0, 1, 0}},
    '{'{0, 0, 0, 1}, '{0, 0, 1, 0}, '{0, 1, 0, 0}, '{1, 0, 0, 0}},
    '{'{1, 0, 0, 0}, '{0, 0, 1, 0}, '{0, 1, 0, 0}, '{0, 0, 0, 1}}
  };

  function automatic mat_t gate_matrix(input logic [FlagBits-1:0] flags);
    int   m [4][4];
    int   r [4][4];
    int   s;
    mat_t res;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        m[i][j] = (i == j) ? 1 : 0;
      end
    end
    for (int g = 0; g < FlagBits; g++) begin
      if (flags[g]) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            s = 0;
            for (int k = 0; k < 4; k++) begin
              s = s + m[i][k] * GateTab[g][k][j];
            end
            r[i][j] = s;
          end
        end
        m = r;
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        res[i][j] = 2'(m[i][j]);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/two_qubit_gate_state_vector.sv =====
// ----------------------------------------------------------------------------
// Two-qubit gate state vector
// Holds complex amplitudes in one single-port memory and applies 4x4 gates.
// ----------------------------------------------------------------------------
// Input beats carry a request: write one amplitude, read one amplitude, or
// apply a transform built from the gate flags to every group of four entries
// that differ in index bits 11:10. Only a read produces an output beat.
// A read passes through the memory read register and then the output
// register. A transform works group by group, paced by the single memory
// port: four reads and four write-backs per group. One item is worked on
// at a time. After reset the memory is cleared one entry a cycle, all
// 2^INDEX_BITS entries, while in_stall_o stays high. When the receiver
// stalls, the output beat is held and in_stall_o stays high, so no new
// request of any kind is taken until the output register has been emptied.
// ----------------------------------------------------------------------------
module two_qubit_gate_state_vector #(
  parameter int INDEX_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tqg_pkg::ReqBits-1:0]  req_type_i,
  input  logic [INDEX_BITS-1:0]     entry_index_i,
  input  tqg_pkg::amp_t             write_real_i,
  input  tqg_pkg::amp_t             write_imag_i,
  input  logic [tqg_pkg::FlagBits-1:0] gate_flags_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tqg_pkg::amp_t             read_real_o,
  output tqg_pkg::amp_t             read_imag_o
);
  import tqg_pkg::*;

  localparam int Depth    = 1 << INDEX_BITS;
  localparam int BaseBits = INDEX_BITS - DirBits;
  localparam int LowMask  = (1 << DirShift) - 1;

  state_e state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;
  logic [BaseBits-1:0]   base_q, base_d;
  logic [2:0]            cnt_q, cnt_d;
  mat_t                  mat_q;
  logic                  halve_q;
  amp_t                  vre_q [4];
  amp_t                  vim_q [4];
  logic                  out_valid_q, out_valid_d;
  amp_t                  out_re_q, out_im_q;

  logic [2*AmpBits-1:0]  mem [Depth];
  logic [2*AmpBits-1:0]  rdata_q;
  logic                  we, re_en;
  logic [INDEX_BITS-1:0] addr;
  logic [2*AmpBits-1:0]  wdata;

  logic                  in_acc;
  logic [INDEX_BITS-1:0] base_ext;
  logic [INDEX_BITS-1:0] grp_addr;
  logic [DirBits-1:0]    dir;
  amp_t                  row_re, row_im;

  function automatic amp_t row_sum(input amp_t v [4], input coef_t c [4], input logic halve);
    logic signed [SumBits-1:0] s;
    logic signed [SumBits:0]   h;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      if (c[k] == 2'sd1) begin
        s = s + SumBits'(v[k]);
      end else if (c[k] == -2'sd1) begin
        s = s - SumBits'(v[k]);
      end
    end
    if (halve) begin
      h = ((SumBits + 1)'(s) + 1) >>> 1;
    end else begin
      h = (SumBits + 1)'(s);
    end
    if (h > (SumBits + 1)'(131071)) begin
      return amp_t'(131071);
    end else if (h < -(SumBits + 1)'(131072)) begin
      return amp_t'(-131072);
    end
    return AmpBits'(h);
  endfunction

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign read_real_o = out_re_q;
  assign read_imag_o = out_im_q;

  assign dir      = cnt_q[DirBits-1:0];
  assign base_ext = INDEX_BITS'(base_q);
  assign grp_addr = ((base_ext >> DirShift) << (DirShift + DirBits))
                  | (INDEX_BITS'(dir) << DirShift)
                  | (base_ext & INDEX_BITS'(LowMask));
  assign row_re   = row_sum(vre_q, mat_q[dir], halve_q);
  assign row_im   = row_sum(vim_q, mat_q[dir], halve_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc && req_type_i == ReqRead) state_d = StReadOut;
        else if (in_acc && req_type_i == ReqTransform) state_d = StGrpRead;
      end
      StReadOut: state_d = StIdle;
      StGrpRead: begin
        if (cnt_q == 3'd4) state_d = StGrpWrite;
      end
      StGrpWrite: begin
        if (cnt_q == 3'd3) state_d = (base_q == '1) ? StIdle : StGrpRead;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    we          = 1'b0;
    re_en       = 1'b0;
    addr        = entry_index_i;
    wdata       = {write_real_i, write_imag_i};
    clr_d       = clr_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        addr  = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        cnt_d  = '0;
        base_d = '0;
        if (in_acc && req_type_i == ReqWrite) we = 1'b1;
        if (in_acc && req_type_i == ReqRead) re_en = 1'b1;
      end
      StReadOut: out_valid_d = 1'b1;
      StGrpRead: begin
        addr  = grp_addr;
        re_en = (cnt_q != 3'd4);
        cnt_d = (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
      end
      StGrpWrite: begin
        we    = 1'b1;
        addr  = grp_addr;
        wdata = {row_re, row_im};
        cnt_d = (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
        if (cnt_q == 3'd3) base_d = base_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re_en) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_acc && req_type_i == ReqTransform) begin
      mat_q   <= gate_matrix(gate_flags_i);
      halve_q <= gate_flags_i[0];
    end
    if (state_q == StGrpRead && cnt_q != 3'd0) begin
      vre_q[cnt_q[1:0] - 2'd1] <= rdata_q[2*AmpBits-1:AmpBits];
      vim_q[cnt_q[1:0] - 2'd1] <= rdata_q[AmpBits-1:0];
    end
    if (state_q == StReadOut) begin
      out_re_q <= rdata_q[2*AmpBits-1:AmpBits];
      out_im_q <= rdata_q[AmpBits-1:0];
    end
  end

endmodule
